>>> hw/rtl/vdh_pkg.sv
// Shared types and constants of the V-disparity histogram block.
`timescale 1ns / 1ps
package vdh_pkg;

  localparam int unsigned VDH_ROW_COUNT = 512;
  localparam int unsigned DISP_BINS     = 256;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned DISP_W     = 8;
  localparam int unsigned COUNT_W    = 8;
  // wide enough to compare a row against any row count up to 4095
  localparam int unsigned ROW_EXT_W  = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [DISP_W-1:0]  LOWER_RESET = 8'd40;
  localparam logic [DISP_W-1:0]  UPPER_RESET = 8'd225;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 1'b0,
    CFG_UPPER = 1'b1
  } cfg_idx_e;

endpackage

>>> hw/rtl/vdh_if.sv
// Stream channel interfaces: command items in, bin counts out.
`timescale 1ns / 1ps
interface vdh_item_if;
  logic                        valid;
  logic                        ready;
  logic [vdh_pkg::CMD_W-1:0]   command;
  logic [vdh_pkg::ROW_W-1:0]   row_index;
  logic [vdh_pkg::DISP_W-1:0]  disparity_value;

  modport source (output valid, command, row_index, disparity_value, input ready);
  modport sink   (input valid, command, row_index, disparity_value, output ready);
endinterface

interface vdh_result_if;
  logic                        valid;
  logic                        ready;
  logic [vdh_pkg::COUNT_W-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

>>> hw/rtl/vdh_ram.sv
// Histogram store: single-port-write, single-port-read RAM, registered read.
`timescale 1ns / 1ps
module vdh_ram #(
  parameter int unsigned AW    = 17,
  parameter int unsigned DEPTH = 131072
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [vdh_pkg::COUNT_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [vdh_pkg::COUNT_W-1:0] rdata_o
);
  import vdh_pkg::*;

  logic [COUNT_W-1:0] mem_q [DEPTH];
  logic [COUNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a write in the same cycle is not seen
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/vdh_outbuf.sv
// Two-entry result buffer between the update stage and the output channel.
`timescale 1ns / 1ps
module vdh_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [vdh_pkg::COUNT_W-1:0] data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [vdh_pkg::COUNT_W-1:0] data_o,
  output logic [1:0]                  occ_o
);
  import vdh_pkg::*;

  logic [COUNT_W-1:0] buf_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         occ_q, occ_d;
  logic               pop;

  assign valid_o = (occ_q != 2'd0);
  assign data_o  = buf_q[rd_ptr_q];
  assign occ_o   = occ_q;
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    occ_d    = occ_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      occ_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/v_disparity_histogram.sv
// Top level of the V-disparity histogram: command decode, read-modify-write, clear sweep.
`timescale 1ns / 1ps
// Usage:
//   in_item carries commands: clear all bins, accumulate one pixel
//   (row, disparity), or read one bin. out_result returns one bin_count beat
//   for each read command, in order; clear and accumulate return nothing.
//   lower_bound and upper_bound are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i; only pixels strictly between them are counted.
// Timing:
//   Accumulates take one item per cycle while no sweep runs and the result
//   buffer does not stall them; back-to-back reads are slowed, as a read is
//   held while one result waits and another is in the update stage. Each
//   item reads the store in the accept cycle and updates or reports in the
//   next, forwarding a same-bin write made in the previous cycle. A read
//   result passes the update stage and the result buffer before it can be
//   taken. A clear is one accept plus a sweep over all ROW_COUNT*256 bins
//   (131072 at the default), one bin per cycle through the single write port; in_item is not ready during the sweep.
// Reset:
//   Reset sets the bounds to 40 and 225 and starts the same sweep.
// Stalls:
//   A two-entry result buffer holds read results; in_item keeps accepting
//   while one result waits and stops when the buffer could overflow.
module v_disparity_histogram #(
  parameter int unsigned ROW_COUNT = vdh_pkg::VDH_ROW_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vdh_item_if.sink                       in_item,
  vdh_result_if.source                   out_result,
  input  logic                           cfg_we_i,
  input  logic [vdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdh_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import vdh_pkg::*;

  localparam int unsigned RowAw = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned Aw    = RowAw + DISP_W;
  localparam int unsigned Depth = ROW_COUNT * DISP_BINS;

  // configuration
  logic [DISP_W-1:0] lower_q, upper_q;

  // clear sweep
  logic          clr_busy_q, clr_busy_d;
  logic [Aw-1:0] clr_ptr_q, clr_ptr_d;

  // update stage
  logic             s1_vld_q;
  logic [CMD_W-1:0] s1_cmd_q;
  logic [Aw-1:0]    s1_addr_q;
  logic             s1_row_ok_q;

  // last write, for same-bin forwarding
  logic               fwd_vld_q;
  logic [Aw-1:0]      fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;

  logic [ROW_EXT_W-1:0] row_ext;
  logic                 in_row_ok;
  logic [Aw-1:0]        in_addr;
  logic                 in_acc;
  logic                 rd_pending;
  logic [1:0]           occ;

  logic [COUNT_W-1:0] rdata;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] new_count;
  logic [DISP_W-1:0]  s1_disp;
  logic               in_window;
  logic               acc_we;
  logic               push;
  logic [COUNT_W-1:0] push_data;

  logic               mem_we;
  logic [Aw-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  // ---------------- input side ----------------
  assign row_ext   = ROW_EXT_W'(in_item.row_index);
  assign in_row_ok = row_ext < ROW_EXT_W'(ROW_COUNT);
  assign in_addr   = {row_ext[RowAw-1:0], in_item.disparity_value};

  assign rd_pending    = s1_vld_q && (s1_cmd_q == CMD_READ);
  assign in_item.ready = !clr_busy_q && ((occ == 2'd0) || ((occ == 2'd1) && !rd_pending));
  assign in_acc        = in_item.valid && in_item.ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOWER: lower_q <= cfg_wdata_i;
        CFG_UPPER: upper_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // ---------------- clear sweep ----------------
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_ptr_d  = clr_ptr_q;
    if (clr_busy_q) begin
      if (clr_ptr_q == Aw'(Depth - 1)) begin
        clr_busy_d = 1'b0;
        clr_ptr_d  = '0;
      end else begin
        clr_ptr_d = clr_ptr_q + Aw'(1);
      end
    end else if (in_acc && (in_item.command == CMD_CLEAR)) begin
      clr_busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_ptr_q  <= clr_ptr_d;
    end
  end

  // ---------------- update stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= in_acc;
      fwd_vld_q <= acc_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q    <= in_item.command;
      s1_addr_q   <= in_addr;
      s1_row_ok_q <= in_row_ok;
    end
    if (acc_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_count;
    end
  end

  assign s1_disp   = s1_addr_q[DISP_W-1:0];
  assign in_window = (s1_disp > lower_q) && (s1_disp < upper_q);
  // take the value written last cycle, which the RAM read did not see
  assign cur_count = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata;
  assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
  assign acc_we    = s1_vld_q && (s1_cmd_q == CMD_ACCUM) && s1_row_ok_q && in_window;
  assign push      = rd_pending;
  assign push_data = s1_row_ok_q ? cur_count : '0;

  // sweep owns the write port while it runs; no item is in flight then
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = acc_we;
      mem_waddr = s1_addr_q;
      mem_wdata = new_count;
    end
  end

  vdh_ram #(
    .AW   (Aw),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (in_acc),
    .raddr_i(in_addr),
    .rdata_o(rdata)
  );

  vdh_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .valid_o(out_result.valid),
    .ready_i(out_result.ready),
    .data_o (out_result.bin_count),
    .occ_o  (occ)
  );

endmodule
